// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the resampling filter RTL
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define UVRF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define UVRF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent on the next edge.
`define UVRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/uvrf_pkg.sv =====
// ---------------------------------------------------------------------------
// uvrf_pkg
// Types, constants and the lane finishing function of the resampling filter.
// ---------------------------------------------------------------------------
`default_nettype none

package uvrf_pkg;

  localparam int LANES      = 8;
  localparam int PIX_W      = 16;
  localparam int ACC_W      = 32;
  localparam int FRAC_BITS  = 14;
  localparam int TAP_W      = 8;
  localparam int OUT_DEPTH  = 8;
  localparam int OPTR_W     = $clog2(OUT_DEPTH);
  localparam int OCNT_W     = $clog2(OUT_DEPTH + 1);

  localparam logic [ACC_W-1:0] ROUND_BIAS   = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [TAP_W-1:0] TAPS_RESET   = TAP_W'(4);
  localparam logic [PIX_W-1:0] PIX_SAT_MAX  = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic [PIX_W-1:0] PIX_SAT_MIN  = {1'b1, {(PIX_W-1){1'b0}}};

  localparam int SH_W = ACC_W - FRAC_BITS;

  typedef logic [LANES-1:0][PIX_W-1:0] pix_vec_t;

  // Control broadcast from the tap sequencer to every lane.
  typedef struct packed {
    logic ld;      // word accepted this cycle: load products
    logic a_vld;   // product stage holds a tap
    logic a_last;  // that tap closes the row
  } lane_ctl_t;

  // Round, shift by FRAC_BITS, clamp to int16, re-bias to unsigned.
  function automatic logic [PIX_W-1:0] finish_lane(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0]       v;
    logic signed [SH_W-1:0] sh;
    logic [PIX_W-1:0]       s;
    v  = acc + ROUND_BIAS;
    sh = $signed(v[ACC_W-1:FRAC_BITS]);
    if (sh > $signed(SH_W'(32767))) begin
      s = PIX_SAT_MAX;
    end else if (sh < $signed(-SH_W'(32768))) begin
      s = PIX_SAT_MIN;
    end else begin
      s = sh[PIX_W-1:0];
    end
    return {~s[PIX_W-1], s[PIX_W-2:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/uvrf_in_if.sv =====
// ---------------------------------------------------------------------------
// uvrf_in_if
// Tap word channel: one Q14 coefficient and eight source pixels.
// ---------------------------------------------------------------------------
`default_nettype none

interface uvrf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coeff;
  logic [15:0]        pix0;
  logic [15:0]        pix1;
  logic [15:0]        pix2;
  logic [15:0]        pix3;
  logic [15:0]        pix4;
  logic [15:0]        pix5;
  logic [15:0]        pix6;
  logic [15:0]        pix7;

  modport source (output valid, coeff, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7,
                  input ready);
  modport sink   (input valid, coeff, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/uvrf_out_if.sv =====
// ---------------------------------------------------------------------------
// uvrf_out_if
// Result word channel: eight filtered output pixels.
// ---------------------------------------------------------------------------
`default_nettype none

interface uvrf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out0;
  logic [15:0] out1;
  logic [15:0] out2;
  logic [15:0] out3;
  logic [15:0] out4;
  logic [15:0] out5;
  logic [15:0] out6;
  logic [15:0] out7;

  modport source (output valid, out0, out1, out2, out3, out4, out5, out6, out7,
                  input ready);
  modport sink   (input valid, out0, out1, out2, out3, out4, out5, out6, out7,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/uvrf_lane.sv =====
// ---------------------------------------------------------------------------
// uvrf_lane
// One column lane: registered multiply, wrapping accumulate, row capture.
// ---------------------------------------------------------------------------
`default_nettype none

module uvrf_lane (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire uvrf_pkg::lane_ctl_t           ctl,
  input  wire logic signed [15:0]            coeff,
  input  wire logic [uvrf_pkg::PIX_W-1:0]    pix,
  output logic [uvrf_pkg::PIX_W-1:0]         fin
);

  localparam int AW = uvrf_pkg::ACC_W;

  logic signed [AW-1:0] prod_r;
  logic [AW-1:0]        acc_r;
  logic [AW-1:0]        acc_nxt;
  logic [AW-1:0]        done_r;
  logic signed [15:0]   pix_s;

  // pix - 32768 is the pixel with its MSB flipped, read as signed
  assign pix_s = $signed({~pix[uvrf_pkg::PIX_W-1], pix[uvrf_pkg::PIX_W-2:0]});

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      prod_r <= AW'(coeff * pix_s);
    end
  end

  assign acc_nxt = acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.a_vld) begin
      acc_r <= ctl.a_last ? '0 : acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.a_vld && ctl.a_last) begin
      done_r <= acc_nxt;
    end
  end

  assign fin = uvrf_pkg::finish_lane(done_r);

endmodule

`default_nettype wire

// ===== rtl/core/uvrf_merge.sv =====
// ---------------------------------------------------------------------------
// uvrf_merge
// Gathers lane results into one word and queues it for the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module uvrf_merge (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 reserve,   // row-closing word accepted
  input  wire logic                 push,      // lane results valid
  input  wire uvrf_pkg::pix_vec_t   lane_fin,
  output logic                      room,
  uvrf_out_if.source                out_bus
);

  localparam int DEPTH = uvrf_pkg::OUT_DEPTH;
  localparam int PW    = uvrf_pkg::OPTR_W;
  localparam int CW    = uvrf_pkg::OCNT_W;

  uvrf_pkg::pix_vec_t mem [DEPTH];
  logic [PW-1:0]      wr_ptr_r;
  logic [PW-1:0]      rd_ptr_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;
  logic [CW-1:0]      cred_r;
  logic [CW-1:0]      cred_nxt;
  logic               pop;
  uvrf_pkg::pix_vec_t head;

  assign pop  = out_bus.valid && out_bus.ready;
  // slots held by rows in flight plus rows queued
  assign room = cred_r < CW'(DEPTH);

  always_comb begin
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
    cred_nxt = cred_r + CW'(reserve) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= lane_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      cred_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      cnt_r  <= cnt_nxt;
      cred_r <= cred_nxt;
    end
  end

  assign head          = mem[rd_ptr_r];
  assign out_bus.valid = cnt_r != '0;
  assign out_bus.out0  = head[0];
  assign out_bus.out1  = head[1];
  assign out_bus.out2  = head[2];
  assign out_bus.out3  = head[3];
  assign out_bus.out4  = head[4];
  assign out_bus.out5  = head[5];
  assign out_bus.out6  = head[6];
  assign out_bus.out7  = head[7];

`include "assert_macros.svh"

  `UVRF_ASSERT_ALWAYS(a_cred_covers_queue, cred_r >= cnt_r, "queue holds an unreserved row")
  `UVRF_ASSERT_ALWAYS(a_cred_bound, cred_r <= CW'(DEPTH), "row reservations exceed depth")
  `UVRF_ASSERT_SAME(a_no_overflow, push && !pop, cnt_r < CW'(DEPTH), "push into full queue")

endmodule

`default_nettype wire

// ===== rtl/core/u16_vertical_resample_filter_unit.sv =====
// ---------------------------------------------------------------------------
// u16_vertical_resample_filter_unit
// Vertical polyphase resampler, Q14 taps, eight 16-bit columns per word.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ----------------------------------
//  in_bus    in   valid / ready      coeff (s16), pix0..pix7 (u16)
//  out_bus   out  valid / ready      out0..out7 (u16)
//  cfg_*     in   cfg_we             cfg_wdata = num_taps (u8)
//
//  One tap word per cycle while in_bus.ready is high. Per lane: one 16x16
//  multiply (registered), then one 32-bit accumulate; the row sum is captured
//  at the last tap and finished on its way into the output queue. A closing
//  word passes the product and row capture registers into the queue. The
//  8-entry output queue decouples the sides; in_bus.ready drops only when
//  eight rows are in flight or waiting. Reset is synchronous, rst_n low.
// ---------------------------------------------------------------------------
`default_nettype none

module u16_vertical_resample_filter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  uvrf_in_if.sink                            in_bus,
  uvrf_out_if.source                         out_bus,
  input  wire logic                          cfg_we,
  input  wire logic [uvrf_pkg::TAP_W-1:0]    cfg_wdata
);

  localparam int TW = uvrf_pkg::TAP_W;

  logic [TW-1:0]        num_taps_r;
  logic [TW-1:0]        taps_r;
  logic [TW:0]          seen;        // one bit wider so 255 + 1 compares cleanly
  logic                 last;
  logic                 accept;
  logic                 a_vld_r;
  logic                 a_last_r;
  logic                 b_vld_r;
  logic                 room;
  uvrf_pkg::lane_ctl_t  ctl;
  uvrf_pkg::pix_vec_t   pix_in;
  uvrf_pkg::pix_vec_t   lane_fin;

  // tap count register; zero behaves as one since seen is never below one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_taps_r <= uvrf_pkg::TAPS_RESET;
    end else if (cfg_we) begin
      num_taps_r <= cfg_wdata;
    end
  end

  assign in_bus.ready = room;
  assign accept       = in_bus.valid && in_bus.ready;

  // row closes once taps seen, this one included, reach num_taps
  assign seen = {1'b0, taps_r} + (TW+1)'(1);
  assign last = seen >= {1'b0, num_taps_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r   <= '0;
      a_vld_r  <= 1'b0;
      a_last_r <= 1'b0;
    end else begin
      if (accept) taps_r <= last ? '0 : seen[TW-1:0];
      a_vld_r  <= accept;
      a_last_r <= accept && last;
    end
  end

  assign ctl.ld     = accept;
  assign ctl.a_vld  = a_vld_r;
  assign ctl.a_last = a_last_r;

  assign pix_in[0] = in_bus.pix0;
  assign pix_in[1] = in_bus.pix1;
  assign pix_in[2] = in_bus.pix2;
  assign pix_in[3] = in_bus.pix3;
  assign pix_in[4] = in_bus.pix4;
  assign pix_in[5] = in_bus.pix5;
  assign pix_in[6] = in_bus.pix6;
  assign pix_in[7] = in_bus.pix7;

  // column lanes, all driven by the same tap sequencer
  for (genvar g = 0; g < uvrf_pkg::LANES; g++) begin : g_lane
    uvrf_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .coeff (in_bus.coeff),
      .pix   (pix_in[g]),
      .fin   (lane_fin[g])
    );
  end

  // row capture registers become valid the cycle after the last tap is summed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r && a_last_r;
    end
  end

  uvrf_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .reserve  (accept && last),
    .push     (b_vld_r),
    .lane_fin (lane_fin),
    .room     (room),
    .out_bus  (out_bus)
  );

`include "assert_macros.svh"

  `UVRF_ASSERT_ALWAYS(a_taps_bound, taps_r != '1, "tap counter ran past the row length")
  `UVRF_ASSERT_NEXT(a_last_clears, accept && last, taps_r == '0 && a_last_r,
                    "row close did not restart the tap count")
  `UVRF_ASSERT_SAME(a_last_has_tap, a_last_r, a_vld_r, "row close flagged without a tap")

endmodule

`default_nettype wire
